// ----- src/tpi_pkg.sv -----
// shared types and constants for the three-plane intersection block
`timescale 1ns / 1ps
package tpi_pkg;
	localparam int CW = 32;             // coefficient width
	localparam int FB = 16;             // fraction bits
	localparam int PW = 2 * CW;         // 32x32 product
	localparam int XW = 2 * CW + 1;     // cross product component
	localparam int HW = CW + 1;         // upper partial operand
	localparam int WW = 3 * CW + 1;     // determinant and numerator
	localparam int NW = WW + FB + 1;    // scaled dividend
	localparam int DW = WW + 1;         // doubled divisor
	localparam int QB = CW + 1;         // quotient bits before saturation
	localparam int RW = DW + QB;        // partial remainder
	localparam int NT = 12;             // product terms
	localparam int LAT = 42;            // start to done

	localparam logic [QB-1:0] LIM_POS = QB'((64'd1 << (CW - 1)) - 64'd1);
	localparam logic [QB-1:0] LIM_NEG = QB'(64'd1 << (CW - 1));

	typedef logic signed [CW-1:0] coef_t;
	typedef logic signed [XW-1:0] crs_t;
	typedef logic signed [WW-1:0] wide_t;

	typedef struct packed {
		coef_t p1_nx;
		coef_t p1_ny;
		coef_t p1_nz;
		coef_t p1_w;
		coef_t p2_nx;
		coef_t p2_ny;
		coef_t p2_nz;
		coef_t p2_w;
		coef_t p3_nx;
		coef_t p3_ny;
		coef_t p3_nz;
		coef_t p3_w;
	} tpi_in_t;

	typedef struct packed {
		logic  found;
		coef_t point_x;
		coef_t point_y;
		coef_t point_z;
		logic  clipped;
	} tpi_out_t;

	typedef struct packed {
		logic [2:0][XW-1:0] bc;
		logic [2:0][XW-1:0] ca;
		logic [2:0][XW-1:0] ab;
		logic [2:0][CW-1:0] a;
		logic [2:0][CW-1:0] w;
	} crs_bus_t;
endpackage

// ----- src/tpi_cross.sv -----
// cross products of the three normals, two stages
`timescale 1ns / 1ps
module tpi_cross (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  tpi_pkg::tpi_in_t  planes,
	output logic              out_valid,
	output tpi_pkg::crs_bus_t bus
);
	import tpi_pkg::*;

	coef_t a [3];
	coef_t b [3];
	coef_t c [3];
	logic signed [PW-1:0] pbc0_s1 [3], pbc1_s1 [3], pca0_s1 [3], pca1_s1 [3];
	logic signed [PW-1:0] pab0_s1 [3], pab1_s1 [3];
	logic [2:0][CW-1:0] a_s1, w_s1;
	logic v_s1, v_s2;
	crs_bus_t bus_s2;

	assign a[0] = planes.p1_nx;
	assign a[1] = planes.p1_ny;
	assign a[2] = planes.p1_nz;
	assign b[0] = planes.p2_nx;
	assign b[1] = planes.p2_ny;
	assign b[2] = planes.p2_nz;
	assign c[0] = planes.p3_nx;
	assign c[1] = planes.p3_ny;
	assign c[2] = planes.p3_nz;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			int j, k;
			j = (i == 2) ? 0 : i + 1;
			k = (i == 0) ? 2 : i - 1;
			pbc0_s1[i] <= b[j] * c[k];
			pbc1_s1[i] <= b[k] * c[j];
			pca0_s1[i] <= c[j] * a[k];
			pca1_s1[i] <= c[k] * a[j];
			pab0_s1[i] <= a[j] * b[k];
			pab1_s1[i] <= a[k] * b[j];
			a_s1[i] <= a[i];
		end
		w_s1 <= {planes.p3_w, planes.p2_w, planes.p1_w};
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			bus_s2.bc[i] <= XW'(pbc0_s1[i]) - XW'(pbc1_s1[i]);
			bus_s2.ca[i] <= XW'(pca0_s1[i]) - XW'(pca1_s1[i]);
			bus_s2.ab[i] <= XW'(pab0_s1[i]) - XW'(pab1_s1[i]);
		end
		bus_s2.a <= a_s1;
		bus_s2.w <= w_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	assign out_valid = v_s2;
	assign bus       = bus_s2;
endmodule

// ----- src/tpi_dot.sv -----
// determinant and numerators from split products, three stages
`timescale 1ns / 1ps
module tpi_dot (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  tpi_pkg::crs_bus_t bus,
	output logic              out_valid,
	output tpi_pkg::wide_t    det,
	output tpi_pkg::wide_t    num_x,
	output tpi_pkg::wide_t    num_y,
	output tpi_pkg::wide_t    num_z
);
	import tpi_pkg::*;

	coef_t m [NT];
	crs_t  x [NT];
	logic signed [CW+HW-1:0] ph_s3 [NT];
	logic signed [CW+HW-1:0] pl_s3 [NT];
	wide_t term_s4 [NT];
	wide_t det_s5, nx_s5, ny_s5, nz_s5;
	logic v_s3, v_s4, v_s5;

	// terms 0..2 build the determinant, then three per coordinate
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			m[i]         = bus.a[i];
			x[i]         = bus.bc[i];
			m[3 + 3 * i] = bus.w[0];
			x[3 + 3 * i] = bus.bc[i];
			m[4 + 3 * i] = bus.w[1];
			x[4 + 3 * i] = bus.ca[i];
			m[5 + 3 * i] = bus.w[2];
			x[5 + 3 * i] = bus.ab[i];
		end
	end

	always_ff @(posedge clk) begin
		for (int t = 0; t < NT; t++) begin
			ph_s3[t] <= m[t] * $signed(x[t][XW-1:CW]);
			pl_s3[t] <= m[t] * $signed({1'b0, x[t][CW-1:0]});
		end
	end

	always_ff @(posedge clk) begin
		for (int t = 0; t < NT; t++)
			term_s4[t] <= (WW'(ph_s3[t]) <<< CW) + WW'(pl_s3[t]);
	end

	always_ff @(posedge clk) begin
		det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
		nx_s5  <= term_s4[3] + term_s4[4] + term_s4[5];
		ny_s5  <= term_s4[6] + term_s4[7] + term_s4[8];
		nz_s5  <= term_s4[9] + term_s4[10] + term_s4[11];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s3 <= in_valid;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign out_valid = v_s5;
	assign det       = det_s5;
	assign num_x     = nx_s5;
	assign num_y     = ny_s5;
	assign num_z     = nz_s5;
endmodule

// ----- src/tpi_div.sv -----
// pipelined restoring divider, one quotient bit per stage, rounding and saturation
`timescale 1ns / 1ps
module tpi_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_tag,
	input  tpi_pkg::wide_t num,
	input  tpi_pkg::wide_t den,
	output logic           out_valid,
	output logic           out_tag,
	output tpi_pkg::coef_t coord,
	output logic           clip
);
	import tpi_pkg::*;

	logic [WW-1:0] nmag, dmag;
	logic          v_s1, v_s2, v_so;
	logic          neg_s1, neg_s2, tag_s1, tag_s2, tag_so;
	logic [NW-1:0] n_s1;
	logic [DW-1:0] d_s1, d_s2;
	logic [RW-1:0] r_s2;
	logic          ovf_s2;
	logic [RW-1:0] r_s   [QB];
	logic [QB-1:0] q_s   [QB];
	logic [DW-1:0] d_s   [QB];
	logic          neg_s [QB];
	logic          ovf_s [QB];
	logic          tag_s [QB];
	logic          v_s   [QB];
	logic [QB-1:0] lim, mag;
	logic          sat;
	coef_t         coord_so;
	logic          clip_so;

	// the numerator is negated, so a positive one over a positive divisor gives a negative point
	assign nmag = num[WW-1] ? WW'(-num) : WW'(num);
	assign dmag = den[WW-1] ? WW'(-den) : WW'(den);

	always_ff @(posedge clk) begin
		neg_s1 <= ((num != '0) && !num[WW-1]) ^ den[WW-1];
		n_s1   <= (NW'(nmag) << (FB + 1)) + NW'(dmag);
		d_s1   <= {dmag, 1'b0};
		tag_s1 <= in_tag;
		neg_s2 <= neg_s1;
		tag_s2 <= tag_s1;
		d_s2   <= d_s1;
		r_s2   <= RW'(n_s1);
		ovf_s2 <= RW'(n_s1) >= (RW'(d_s1) << QB);
	end

	for (genvar k = 0; k < QB; k++) begin : g_bit
		logic [RW-1:0] r_in, trial;
		logic [QB-1:0] q_in;
		logic [DW-1:0] d_in;
		logic          neg_in, ovf_in, tag_in, v_in;

		if (k == 0) begin : g_first
			assign r_in   = r_s2;
			assign q_in   = '0;
			assign d_in   = d_s2;
			assign neg_in = neg_s2;
			assign ovf_in = ovf_s2;
			assign tag_in = tag_s2;
			assign v_in   = v_s2;
		end else begin : g_next
			assign r_in   = r_s[k-1];
			assign q_in   = q_s[k-1];
			assign d_in   = d_s[k-1];
			assign neg_in = neg_s[k-1];
			assign ovf_in = ovf_s[k-1];
			assign tag_in = tag_s[k-1];
			assign v_in   = v_s[k-1];
		end

		assign trial = RW'(d_in) << (QB - 1 - k);

		always_ff @(posedge clk) begin
			if (r_in >= trial) begin
				r_s[k] <= r_in - trial;
				q_s[k] <= q_in | (QB'(1) << (QB - 1 - k));
			end else begin
				r_s[k] <= r_in;
				q_s[k] <= q_in;
			end
			d_s[k]   <= d_in;
			neg_s[k] <= neg_in;
			ovf_s[k] <= ovf_in;
			tag_s[k] <= tag_in;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_in;
			end
		end
	end

	assign lim = neg_s[QB-1] ? LIM_NEG : LIM_POS;
	assign sat = ovf_s[QB-1] || (q_s[QB-1] > lim);
	assign mag = sat ? lim : q_s[QB-1];

	always_ff @(posedge clk) begin
		coord_so <= neg_s[QB-1] ? -mag[CW-1:0] : mag[CW-1:0];
		clip_so  <= sat;
		tag_so   <= tag_s[QB-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_so <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_so <= v_s[QB-1];
		end
	end

	assign out_valid = v_so;
	assign out_tag   = tag_so;
	assign coord     = coord_so;
	assign clip      = clip_so;
endmodule

// ----- src/three_plane_intersection.sv -----
// top level: intersection point of three planes in Q16.16
`timescale 1ns / 1ps
// Takes one transaction per clock (busy never rises) and returns one result
// per transaction, in order, strobed by done for a single cycle; the receiver
// cannot stall, so results must be taken when shown. The divider holds 33
// quotient bit stages plus setup, rounding and saturation, behind 2
// cross-product and 3 dot-product stages, ahead of an output register.
// A zero determinant gives found low and all other fields zero.
// Coordinates are rounded to nearest, ties away from zero, and saturated to
// the signed 32-bit range with clipped set.
module three_plane_intersection (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  tpi_pkg::tpi_in_t  planes,
	output logic              done,
	output tpi_pkg::tpi_out_t result
);
	import tpi_pkg::*;

	logic     accept;
	logic     crs_valid, dot_valid;
	crs_bus_t crs_bus;
	wide_t    det, num_x, num_y, num_z;
	logic     found;
	logic     vx, vy, vz, tag_x, tag_y, tag_z;
	coef_t    cx, cy, cz;
	logic     clx, cly, clz;
	logic     done_q;
	tpi_out_t result_q;

	// fully pipelined, never holds off a transaction
	assign busy   = 1'b0;
	assign accept = start && !busy;

	tpi_cross u_cross (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.planes   (planes),
		.out_valid(crs_valid),
		.bus      (crs_bus)
	);

	tpi_dot u_dot (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (crs_valid),
		.bus      (crs_bus),
		.out_valid(dot_valid),
		.det      (det),
		.num_x    (num_x),
		.num_y    (num_y),
		.num_z    (num_z)
	);

	// singular flag rides along with all three dividers; the x copy is used
	assign found = (det != '0);

	tpi_div u_div_x (
		.clk(clk), .arst_n(arst_n), .in_valid(dot_valid), .in_tag(found),
		.num(num_x), .den(det), .out_valid(vx), .out_tag(tag_x),
		.coord(cx), .clip(clx)
	);

	tpi_div u_div_y (
		.clk(clk), .arst_n(arst_n), .in_valid(dot_valid), .in_tag(found),
		.num(num_y), .den(det), .out_valid(vy), .out_tag(tag_y),
		.coord(cy), .clip(cly)
	);

	tpi_div u_div_z (
		.clk(clk), .arst_n(arst_n), .in_valid(dot_valid), .in_tag(found),
		.num(num_z), .den(det), .out_valid(vz), .out_tag(tag_z),
		.coord(cz), .clip(clz)
	);

	// output register, zero everything on a singular set of planes
	always_ff @(posedge clk) begin
		result_q.found   <= tag_x;
		result_q.point_x <= tag_x ? cx : '0;
		result_q.point_y <= tag_x ? cy : '0;
		result_q.point_z <= tag_x ? cz : '0;
		result_q.clipped <= tag_x && (clx || cly || clz);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vx;
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	// every transaction comes back after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done)
		else $error("result missing after fixed latency");

	// the three divider lanes stay in step
	a_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		(vx == vy) && (vx == vz) && (!vx || ((tag_x == tag_y) && (tag_x == tag_z))))
		else $error("divider lanes out of step");

	// singular result carries no point and no clip
	a_singular: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.found) |->
		(result.point_x == '0) && (result.point_y == '0) &&
		(result.point_z == '0) && !result.clipped)
		else $error("singular result not cleared");
`endif
endmodule
